// ===== design/fdt_first_subnode_scanner_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the device tree subnode scanner
// Clocked checks on clk_i that are held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FDT_FIRST_SUBNODE_SCANNER_TOP_MACROS_SVH
`define FDT_FIRST_SUBNODE_SCANNER_TOP_MACROS_SVH

// Property must hold at every clock edge out of reset
`define FDTSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define FDTSS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== design/fdtss_pkg.sv =====
// ----------------------------------------------------------------------------
// fdtss_pkg
// Shared tags, result codes and types for the device tree subnode scanner.
// ----------------------------------------------------------------------------
package fdtss_pkg;

  // Structure block tokens
  localparam logic [31:0] TAG_BEGIN_NODE = 32'h0000_0001;
  localparam logic [31:0] TAG_END_NODE   = 32'h0000_0002;
  localparam logic [31:0] TAG_PROP       = 32'h0000_0003;
  localparam logic [31:0] TAG_NOP        = 32'h0000_0004;
  localparam logic [31:0] TAG_END        = 32'h0000_0009;

  localparam int unsigned IndexOutBits = 16;

  // Result codes
  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_END     = 2'd1,
    ST_INVALID = 2'd2,
    ST_LIMIT   = 2'd3
  } status_e;

  // Word held in the input stage
  typedef struct packed {
    logic [31:0] word;
    logic        first;
  } in_word_t;

  // Result of one parse step
  typedef struct packed {
    logic                    hit;
    status_e                 status;
    logic [IndexOutBits-1:0] index;
    logic [31:0]             bad_tag;
  } step_res_t;

  // True when any byte of the word is zero (end of a node name)
  function automatic logic has_zero_byte(input logic [31:0] w);
    has_zero_byte = (w[31:24] == 8'h00) || (w[23:16] == 8'h00) ||
                    (w[15:8] == 8'h00) || (w[7:0] == 8'h00);
  endfunction

endpackage

// ===== design/fdtss_in_stage.sv =====
// ----------------------------------------------------------------------------
// fdtss_in_stage
// Input register: holds one word until the parser consumes it.
// ----------------------------------------------------------------------------
module fdtss_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        word_i,
  input  logic               first_i,
  input  logic               advance_i,
  output logic               full_o,
  output fdtss_pkg::in_word_t data_o
);

  logic                valid_q;
  fdtss_pkg::in_word_t data_q;

  // Take a new word when empty or when the held word moves on this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q.word  <= word_i;
      data_q.first <= first_i;
    end
  end

  assign full_o = valid_q;
  assign data_o = data_q;

endmodule

// ===== design/fdtss_parser.sv =====
// ----------------------------------------------------------------------------
// fdtss_parser
// Token parser: phase, depth, word index and property skip count, updated
// once per consumed word, with the result of that word decided in the same
// cycle.
// ----------------------------------------------------------------------------
module fdtss_parser #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  fdtss_pkg::in_word_t  data_i,
  output fdtss_pkg::step_res_t res_o
);

  localparam logic [2:0] PH_HALT      = 3'd0;
  localparam logic [2:0] PH_TAG       = 3'd1;
  localparam logic [2:0] PH_NAME      = 3'd2;
  localparam logic [2:0] PH_PLEN      = 3'd3;
  localparam logic [2:0] PH_PNAMEOFF  = 3'd4;
  localparam logic [2:0] PH_PDATA     = 3'd5;
  localparam logic [2:0] PH_PNAMEOFF0 = 3'd6;

  logic [2:0]            phase_q, phase_d;
  logic [1:0]            depth_q, depth_d;
  logic [INDEX_BITS-1:0] count_q, count_d;
  logic [29:0]           skip_q, skip_d;

  logic [2:0]            ph;
  logic [1:0]            dep;
  logic [1:0]            dep_inc;
  logic [INDEX_BITS-1:0] cnt;
  logic [29:0]           skp;
  logic [31:0]           w;
  logic [32:0]           plen_pad;
  logic [30:0]           plen_skip;
  logic [31:0]           cnt_ext;
  logic                  emit;

  assign w         = data_i.word;
  assign plen_pad  = {1'b0, w} + 33'd3;
  assign plen_skip = plen_pad[32:2] - 31'd1;

  always_comb begin
    // A start word restarts the scan before it is parsed
    ph  = data_i.first ? PH_TAG : phase_q;
    dep = data_i.first ? 2'd0 : depth_q;
    cnt = data_i.first ? '0 : count_q;
    skp = data_i.first ? 30'd0 : skip_q;

    dep_inc = dep + 2'd1;
    cnt_ext = 32'(cnt);

    phase_d = ph;
    depth_d = dep;
    count_d = cnt;
    skip_d  = skp;
    emit    = 1'b0;

    res_o.hit     = 1'b0;
    res_o.status  = fdtss_pkg::ST_FOUND;
    res_o.index   = cnt_ext[fdtss_pkg::IndexOutBits-1:0];
    res_o.bad_tag = 32'd0;

    unique case (ph)
      PH_HALT: begin
        phase_d = PH_HALT;
      end
      PH_TAG: begin
        if (w == fdtss_pkg::TAG_BEGIN_NODE) begin
          depth_d = dep_inc;
          if (dep_inc == 2'd2) begin
            emit         = 1'b1;
            res_o.status = fdtss_pkg::ST_FOUND;
          end else begin
            phase_d = PH_NAME;
          end
        end else if (w == fdtss_pkg::TAG_END_NODE) begin
          if (dep != 2'd0) begin
            depth_d = dep - 2'd1;
          end
        end else if (w == fdtss_pkg::TAG_NOP) begin
          phase_d = PH_TAG;
        end else if (w == fdtss_pkg::TAG_PROP) begin
          phase_d = PH_PLEN;
        end else if (w == fdtss_pkg::TAG_END) begin
          emit         = 1'b1;
          res_o.status = fdtss_pkg::ST_END;
        end else begin
          emit          = 1'b1;
          res_o.status  = fdtss_pkg::ST_INVALID;
          res_o.bad_tag = w;
        end
      end
      PH_NAME: begin
        if (fdtss_pkg::has_zero_byte(w)) begin
          phase_d = PH_TAG;
        end
      end
      PH_PLEN: begin
        // Pad length up to whole words; zero length has no data words
        if (w == 32'd0) begin
          skip_d  = 30'd0;
          phase_d = PH_PNAMEOFF0;
        end else begin
          skip_d  = plen_skip[29:0];
          phase_d = PH_PNAMEOFF;
        end
      end
      PH_PNAMEOFF: begin
        phase_d = PH_PDATA;
      end
      PH_PNAMEOFF0: begin
        phase_d = PH_TAG;
      end
      PH_PDATA: begin
        if (skp == 30'd0) begin
          phase_d = PH_TAG;
        end else begin
          skip_d = skp - 30'd1;
        end
      end
      default: begin
        phase_d = PH_HALT;
      end
    endcase

    // Saturate the word index, or advance it
    if (ph != PH_HALT && ph != PH_TAG && ph != PH_NAME && ph != PH_PLEN &&
        ph != PH_PNAMEOFF && ph != PH_PDATA && ph != PH_PNAMEOFF0) begin
      emit = 1'b0;
    end else if (ph != PH_HALT && !emit) begin
      if (&cnt) begin
        emit         = 1'b1;
        res_o.status = fdtss_pkg::ST_LIMIT;
      end else begin
        count_d = cnt + 1'b1;
      end
    end

    if (emit) begin
      phase_d = PH_HALT;
    end
    res_o.hit = emit;
  end

  // Commit state on each consumed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HALT;
      depth_q <= 2'd0;
      count_q <= '0;
      skip_q  <= 30'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      depth_q <= depth_d;
      count_q <= count_d;
      skip_q  <= skip_d;
    end
  end

endmodule

// ===== design/fdt_first_subnode_scanner_top.sv =====
// ----------------------------------------------------------------------------
// fdt_first_subnode_scanner_top
// Streams device tree structure block words and reports the first subnode.
// ----------------------------------------------------------------------------
// Takes one structure block word per cycle, back to back, unless a result
// waits: a word is held in the input register, is parsed and lands in the
// result register, which drives the outputs.
// The rate is set by the single parse step between those two registers:
// one word per cycle, held off only while a result waits on out_ready_i.
// Set first_i on the tag word at index 0 to start a scan; after any result
// all words are dropped until the next start. node_index_o is the word index
// within the scan (low 16 bits), and status ST_LIMIT reports the last index
// 2^INDEX_BITS - 1 when that word ends the scan.
// ----------------------------------------------------------------------------
`include "fdt_first_subnode_scanner_top_macros.svh"

module fdt_first_subnode_scanner_top #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] word_i,
  input  logic        first_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] node_index_o,
  output logic [31:0] bad_tag_o
);

  fdtss_pkg::in_word_t  in_word;
  fdtss_pkg::step_res_t step_res;
  logic                 in_full;
  logic                 advance;

  logic                 out_valid_q;
  logic [1:0]           status_q;
  logic [15:0]          index_q;
  logic [31:0]          bad_tag_q;

  // Move the held word on when the result register can take its result
  assign advance = in_full && (!out_valid_q || out_ready_i);

  fdtss_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .word_i     (word_i),
    .first_i    (first_i),
    .advance_i  (advance),
    .full_o     (in_full),
    .data_o     (in_word)
  );

  fdtss_parser #(
    .INDEX_BITS (INDEX_BITS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .data_i (in_word),
    .res_o  (step_res)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step_res.hit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (advance && step_res.hit) begin
      status_q  <= 2'(step_res.status);
      index_q   <= step_res.index;
      bad_tag_q <= step_res.bad_tag;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign node_index_o = index_q;
  assign bad_tag_o    = bad_tag_q;

  // Checks
  logic [INDEX_BITS-1:0] max_index;
  logic [31:0]           max_index_ext;
  assign max_index     = '1;
  assign max_index_ext = 32'(max_index);

  `FDTSS_ASSERT_IMPL(a_bad_tag_only_invalid, out_valid_o && bad_tag_o != 32'd0,
    status_o == 2'(fdtss_pkg::ST_INVALID), "bad_tag set on a non-invalid result")
  `FDTSS_ASSERT_IMPL(a_limit_index, out_valid_o && status_o == 2'(fdtss_pkg::ST_LIMIT),
    node_index_o == max_index_ext[15:0], "limit result with wrong index")
  `FDTSS_ASSERT(a_stall_cause, in_ready_o || (out_valid_o && !out_ready_i),
    "input stalled without a waiting result")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for fdt_first_subnode_scanner_top: streams structure block words
// (directed token sequences and random well-formed trees mixed with noise)
// and checks every result against a scan predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned INDEX_BITS     = 16;
  localparam int unsigned LAST_INDEX     = (1 << INDEX_BITS) - 1;
  localparam int unsigned RANDOM_WORDS   = 1700;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  // Parser phases of the predictor
  typedef enum logic [2:0] {
    P_HALT, P_TAG, P_NAME, P_PLEN, P_NAMEOFF, P_NAMEOFF_NODATA, P_DATA
  } scan_phase_e;

  typedef struct packed {
    fdtss_pkg::status_e status;
    logic [15:0]        node_index;
    logic [31:0]        bad_tag;
  } scan_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [31:0] word_i      = '0;
  logic        first_i     = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [15:0] node_index_o;
  logic [31:0] bad_tag_o;

  // Predictor state
  scan_phase_e           scan_phase = P_HALT;
  logic [1:0]            node_depth = '0;
  logic [INDEX_BITS-1:0] word_index = '0;
  logic [29:0]           data_left  = '0;
  scan_result_t          pending_results[$];
  scan_result_t          oldest_result;

  int unsigned sent_words     = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned ready_left     = 0;
  logic        idle_on        = 1'b1;

  fdt_first_subnode_scanner_top #(
    .INDEX_BITS(INDEX_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .word_i      (word_i),
    .first_i     (first_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .node_index_o(node_index_o),
    .bad_tag_o   (bad_tag_o)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Advance the scan by one accepted word and queue any result it causes
  task automatic parse_word(input logic [31:0] w, input logic is_first);
    scan_result_t res;
    logic         done;
    logic         zero_seen;
    logic [32:0]  len_words;
    done      = 1'b0;
    zero_seen = 1'b0;
    res       = '0;
    if (is_first) begin
      scan_phase = P_TAG;
      node_depth = '0;
      word_index = '0;
      data_left  = '0;
    end
    if (scan_phase == P_HALT) return;
    case (scan_phase)
      P_TAG: begin
        if (w == fdtss_pkg::TAG_BEGIN_NODE) begin
          node_depth = node_depth + 2'd1;
          if (node_depth == 2'd2) begin
            res.status = fdtss_pkg::ST_FOUND;
            done       = 1'b1;
          end else begin
            scan_phase = P_NAME;
          end
        end else if (w == fdtss_pkg::TAG_END_NODE) begin
          if (node_depth != 2'd0) node_depth = node_depth - 2'd1;
        end else if (w == fdtss_pkg::TAG_PROP) begin
          scan_phase = P_PLEN;
        end else if (w == fdtss_pkg::TAG_END) begin
          res.status = fdtss_pkg::ST_END;
          done       = 1'b1;
        end else if (w != fdtss_pkg::TAG_NOP) begin
          res.status  = fdtss_pkg::ST_INVALID;
          res.bad_tag = w;
          done        = 1'b1;
        end
      end
      P_NAME: begin
        for (int b = 0; b < 4; b++) if (w[8*b +: 8] == 8'h00) zero_seen = 1'b1;
        if (zero_seen) scan_phase = P_TAG;
      end
      P_PLEN: begin
        len_words = ({1'b0, w} + 33'd3) >> 2;
        if (len_words == '0) begin
          data_left  = '0;
          scan_phase = P_NAMEOFF_NODATA;
        end else begin
          data_left  = 30'(len_words - 33'd1);
          scan_phase = P_NAMEOFF;
        end
      end
      P_NAMEOFF:        scan_phase = P_DATA;
      P_NAMEOFF_NODATA: scan_phase = P_TAG;
      P_DATA: begin
        if (data_left == '0) scan_phase = P_TAG;
        else data_left = data_left - 30'd1;
      end
      default: scan_phase = P_HALT;
    endcase
    res.node_index = 16'(word_index);
    if (!done) begin
      if (word_index == INDEX_BITS'(LAST_INDEX)) begin
        res.status = fdtss_pkg::ST_LIMIT;
        done       = 1'b1;
      end else begin
        word_index = word_index + 1'b1;
      end
    end
    if (done) begin
      pending_results.push_back(res);
      scan_phase = P_HALT;
    end
  endtask

  // Predict on every accepted input word
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) parse_word(word_i, first_i);
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d index %0d tag %h",
                                  status_o, node_index_o, bad_tag_o));
      end else begin
        oldest_result = pending_results.pop_front();
        if (status_o !== oldest_result.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    status_o, oldest_result.status));
        if (node_index_o !== oldest_result.node_index)
          report_mismatch($sformatf("node_index %0d, expected %0d",
                                    node_index_o, oldest_result.node_index));
        if (bad_tag_o !== oldest_result.bad_tag)
          report_mismatch($sformatf("bad_tag %h, expected %h",
                                    bad_tag_o, oldest_result.bad_tag));
      end
    end
  end

  // Receiver: ready stretches and stall bursts
  always @(posedge clk_i) begin
    if (!idle_on) begin
      out_ready_i <= 1'b1;
      ready_left  <= 0;
    end else if (ready_left == 0) begin
      if (out_ready_i && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        ready_left  <= $urandom_range(0, 17);
      end else begin
        out_ready_i <= 1'b1;
        ready_left  <= $urandom_range(1, 30);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("fdt_first_subnode_scanner_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word, sometimes after a random gap, and hold it until accepted
  task automatic send_word(input logic [31:0] w, input logic is_first);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    word_i     <= w;
    first_i    <= is_first;
    do @(posedge clk_i); while (!in_ready_o);
    sent_words++;
  endtask

  function automatic logic [31:0] word_without_zero();
    return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
            8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
  endfunction

  // Mix of arbitrary words, small token-like values and one-hot values
  function automatic logic [31:0] random_tag();
    case ($urandom_range(0, 2))
      0:       return $urandom;
      1:       return 32'($urandom_range(0, 15));
      default: return 32'h1 << $urandom_range(0, 31);
    endcase
  endfunction

  // Node name: words without a zero byte, then one that ends the string
  task automatic send_node_name();
    logic [31:0] w;
    int          pos;
    repeat ($urandom_range(0, 3)) send_word(word_without_zero(), 1'b0);
    w   = word_without_zero();
    pos = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) w = '0;
    else w[8*pos +: 8] = 8'h00;
    send_word(w, 1'b0);
  endtask

  // Property token; data is cut off after max_data words
  task automatic send_property(input logic [31:0] len, input int max_data);
    longint n_data;
    n_data = (longint'(len) + 3) >> 2;
    if (n_data > max_data) n_data = max_data;
    send_word(fdtss_pkg::TAG_PROP, 1'b0);
    send_word(len, 1'b0);
    send_word($urandom, 1'b0);
    repeat (n_data) send_word($urandom, 1'b0);
  endtask

  // Words before the first start are dropped
  task automatic test_idle_after_reset();
    send_word(fdtss_pkg::TAG_END, 1'b0);
    send_word(fdtss_pkg::TAG_BEGIN_NODE, 1'b0);
    send_word(32'hDEAD_BEEF, 1'b0);
  endtask

  // Walk begin, property, nop and end-node tokens before reaching the first subnode
  task automatic test_first_subnode();
    send_word(fdtss_pkg::TAG_BEGIN_NODE, 1'b1);
    send_word(32'h0000_0000, 1'b0);     // empty root name
    send_word(fdtss_pkg::TAG_PROP, 1'b0); // zero length: no data
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0010, 1'b0);
    send_property(32'd5, 2);
    send_word(fdtss_pkg::TAG_NOP, 1'b0);
    send_word(fdtss_pkg::TAG_END_NODE, 1'b0);   // depth back to zero
    send_word(fdtss_pkg::TAG_END_NODE, 1'b0);   // saturates at zero
    send_word(fdtss_pkg::TAG_BEGIN_NODE, 1'b0);
    send_word(32'h6370_7500, 1'b0);     // "cpu"
    send_word(fdtss_pkg::TAG_BEGIN_NODE, 1'b0); // depth two: found
  endtask

  // End token, invalid tags, ignored trailers and a restart mid-property
  task automatic test_terminators();
    send_word(fdtss_pkg::TAG_END, 1'b1);
    send_word(fdtss_pkg::TAG_BEGIN_NODE, 1'b0); // dropped after a result
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h0000_0000, 1'b1);
    send_word(fdtss_pkg::TAG_BEGIN_NODE, 1'b1);
    send_word(32'h0000_0000, 1'b0);
    send_property(32'hFFFF_FFFF, 3);
    send_word(fdtss_pkg::TAG_END, 1'b1);        // restart wins over the property
  endtask

  // One random scan: mostly well-formed trees, some noise and broken ones
  task automatic send_random_scan();
    int pick;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) send_word(random_tag(), $urandom_range(0, 7) == 0);
      return;
    end
    send_word(($urandom_range(0, 11) == 0) ? random_tag() : fdtss_pkg::TAG_BEGIN_NODE,
              1'b1);
    send_node_name();
    repeat ($urandom_range(0, 8)) begin
      pick = $urandom_range(0, 11);
      if (pick < 5) send_property($urandom_range(0, 24), 16);
      else if (pick < 7) send_property($urandom_range(25, 200), 64);
      else if (pick == 8) send_word(fdtss_pkg::TAG_END_NODE, 1'b0);
      else if (pick == 9) begin
        send_word(fdtss_pkg::TAG_BEGIN_NODE, 1'b0);
        send_node_name();
      end else if (pick == 10) send_property($urandom, $urandom_range(0, 6));
      else send_word(fdtss_pkg::TAG_NOP, 1'b0);
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) send_word(fdtss_pkg::TAG_BEGIN_NODE, 1'b0);
    else if (pick == 5) send_word(fdtss_pkg::TAG_END, 1'b0);
    else if (pick == 6) send_word(random_tag(), 1'b0);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) send_word(random_tag(), 1'b0);
  endtask

  task automatic test_random_scans();
    int unsigned base;
    base    = sent_words;
    idle_on = 1'b1;
    while (sent_words - base < RANDOM_WORDS) begin
      // no idling in the last quarter
      if (sent_words - base >= RANDOM_WORDS * 3 / 4) idle_on = 1'b0;
      send_random_scan();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_after_reset();
    test_first_subnode();
    test_terminators();
    test_random_scans();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("fdt_first_subnode_scanner_top test passed");
    end else begin
      $display("fdt_first_subnode_scanner_top test failed");
    end
    $finish;
  end

endmodule
